### sv/xpr_pkg.sv
// Shared types, protocol byte codes and the CRC-16 byte update for the XMODEM receiver.
package xpr_pkg;

  localparam logic [7:0]  BYTE_EOT = 8'h04;
  localparam logic [7:0]  BYTE_ACK = 8'h06;
  localparam logic [7:0]  BYTE_NAK = 8'h15;
  localparam logic [7:0]  BYTE_C   = 8'h43;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  // Header bytes skipped after the start byte, and the data bytes per packet.
  localparam int unsigned NUM_HDR  = 2;
  localparam int unsigned DATA_LEN = 128;
  localparam int unsigned POS_W    = 8;

  localparam logic [POS_W-1:0] POS_DATA_FIRST = POS_W'(NUM_HDR);
  localparam logic [POS_W-1:0] POS_CHECK_HI   = POS_W'(NUM_HDR + DATA_LEN);

  typedef enum logic {
    KIND_REPLY = 1'b0,
    KIND_DATA  = 1'b1
  } kind_e;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_BYTE  = 1'b1
  } mode_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic       packet_end;
    logic       accepted;
    logic       transfer_done;
  } res_t;

  // One byte of CRC-16 (poly 0x1021, MSB first), one bit per iteration.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### sv/xpr_if.sv
// Valid/ready channel interfaces for the received-byte input and the result output.
interface xpr_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface xpr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;
  logic       packet_end;
  logic       accepted;
  logic       transfer_done;

  modport source (output valid, output kind, output byte_value, output packet_end,
                  output accepted, output transfer_done, input ready);
  modport sink   (input valid, input kind, input byte_value, input packet_end,
                  input accepted, input transfer_done, output ready);
endinterface

### sv/xpr_core.sv
// Packet state, check accumulators and the per-byte reply decision of the receiver.
module xpr_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic          mode_i,
  input  logic [7:0]    rx_byte_i,
  input  logic          use_crc_i,
  output logic          res_valid_o,
  output xpr_pkg::res_t res_o
);

  logic                       phase_q, phase_d;
  logic [xpr_pkg::POS_W-1:0]  pos_q, pos_d;
  logic [15:0]                crc_q, crc_d;
  logic [7:0]                 sum_q, sum_d;
  logic [7:0]                 chk_hi_q, chk_hi_d;
  logic                       ok;
  logic [15:0]                crc_next;

  assign crc_next = xpr_pkg::crc_byte(crc_q, rx_byte_i);

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    crc_d       = crc_q;
    sum_d       = sum_q;
    chk_hi_d    = chk_hi_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    ok          = 1'b0;

    if (mode_i == xpr_pkg::MODE_START) begin
      // A start item restarts the transfer even in mid-packet.
      phase_d          = 1'b0;
      pos_d            = '0;
      crc_d            = '0;
      sum_d            = '0;
      chk_hi_d         = '0;
      res_valid_o      = 1'b1;
      res_o.kind       = xpr_pkg::KIND_REPLY;
      res_o.byte_value = use_crc_i ? xpr_pkg::BYTE_C : xpr_pkg::BYTE_NAK;
    end else if (!phase_q) begin
      if (rx_byte_i == xpr_pkg::BYTE_EOT) begin
        res_valid_o         = 1'b1;
        res_o.kind          = xpr_pkg::KIND_REPLY;
        res_o.byte_value    = xpr_pkg::BYTE_ACK;
        res_o.transfer_done = 1'b1;
      end else begin
        phase_d  = 1'b1;
        pos_d    = '0;
        crc_d    = '0;
        sum_d    = '0;
        chk_hi_d = '0;
      end
    end else if (pos_q < xpr_pkg::POS_DATA_FIRST) begin
      pos_d = pos_q + 1'b1;
    end else if (pos_q < xpr_pkg::POS_CHECK_HI) begin
      crc_d            = crc_next;
      sum_d            = sum_q + rx_byte_i;
      pos_d            = pos_q + 1'b1;
      res_valid_o      = 1'b1;
      res_o.kind       = xpr_pkg::KIND_DATA;
      res_o.byte_value = rx_byte_i;
    end else if (use_crc_i && (pos_q == xpr_pkg::POS_CHECK_HI)) begin
      chk_hi_d = rx_byte_i;
      pos_d    = pos_q + 1'b1;
    end else begin
      ok               = use_crc_i ? ({chk_hi_q, rx_byte_i} == crc_q) : (rx_byte_i == sum_q);
      phase_d          = 1'b0;
      pos_d            = '0;
      crc_d            = '0;
      sum_d            = '0;
      chk_hi_d         = '0;
      res_valid_o      = 1'b1;
      res_o.kind       = xpr_pkg::KIND_REPLY;
      res_o.byte_value = ok ? xpr_pkg::BYTE_ACK : xpr_pkg::BYTE_NAK;
      res_o.packet_end = 1'b1;
      res_o.accepted   = ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 1'b0;
      pos_q    <= '0;
      crc_q    <= '0;
      sum_q    <= '0;
      chk_hi_q <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      crc_q    <= crc_d;
      sum_q    <= sum_d;
      chk_hi_q <= chk_hi_d;
    end
  end

endmodule

### sv/xmodem_packet_receiver_top.sv
// Top level of the XMODEM receiver: input register, packet core and result register.
//
// Usage: each item on in_i is either a start request (mode 0) or one byte taken from
// the serial line (mode 1). Start requests produce the initiation byte (0x43 in CRC
// mode, NAK in checksum mode). Line bytes are parsed as XMODEM packets; the 128 data
// bytes come out on out_o as kind 1 items as they arrive, and the packet closes with
// an ACK or NAK reply item (packet_end set, accepted set on ACK). Downstream keeps
// the forwarded data of a packet only when its closing item has accepted set. An EOT
// between packets is answered with ACK and transfer_done set.
// cfg_we_i/cfg_wdata_i write use_crc (reset 1); write it only while the block is idle.
// A result is presented on out_o from the result register: the input register takes
// the item at the accept edge and the result register when the item moves on.
// Throughput is one item per cycle unless out_o stalls; CRC update is combinational.
// Reset returns the block to waiting for a header with cleared accumulators and empty
// registers. When out_o stalls, the result register holds its item and one more item
// waits in the input register; in_i.ready then drops until out_o takes the result.
module xmodem_packet_receiver_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  cfg_we_i,
  input  logic  cfg_wdata_i,
  xpr_in_if.sink    in_i,
  xpr_out_if.source out_o
);

  logic          use_crc_q;
  logic          in_vld_q;
  logic          in_mode_q;
  logic [7:0]    in_byte_q;
  logic          out_vld_q;
  xpr_pkg::res_t out_res_q;
  logic          adv;
  logic          res_vld;
  xpr_pkg::res_t res;

  // The held item moves on when the result register is empty or being emptied.
  assign adv        = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_crc_q <= 1'b1;
    end else if (cfg_we_i) begin
      use_crc_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_mode_q <= in_i.mode;
      in_byte_q <= in_i.rx_byte;
    end
  end

  xpr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (adv),
    .mode_i      (in_mode_q),
    .rx_byte_i   (in_byte_q),
    .use_crc_i   (use_crc_q),
    .res_valid_o (res_vld),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res_vld;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.kind          = out_res_q.kind;
  assign out_o.byte_value    = out_res_q.byte_value;
  assign out_o.packet_end    = out_res_q.packet_end;
  assign out_o.accepted      = out_res_q.accepted;
  assign out_o.transfer_done = out_res_q.transfer_done;

endmodule

### verif/tb_xmodem_packet_receiver_top.sv
// Self-checking testbench for the XMODEM packet receiver with a scoreboard-based predictor.
module tb_xmodem_packet_receiver_top;

  // Tracks the receiver's packet state and keeps the outputs that are still owed by the block.
  class rx_scoreboard;
    bit                  crc_mode;
    bit                  in_packet;
    logic [7:0]          pos;
    logic [15:0]         crc_acc;
    logic [7:0]          sum_acc;
    logic [7:0]          check_hi;
    xpr_pkg::res_t       outputs_due[$];
    int unsigned         mismatches;
    int unsigned         results_seen;

    function new();
      crc_mode = 1'b1;
      mismatches = 0;
      results_seen = 0;
      clear_packet();
    endfunction

    // CRC-16 with polynomial 0x1021, taking the data bits MSB first.
    static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ d[i];
        c = {c[14:0], 1'b0};
        if (fb) c = c ^ xpr_pkg::CRC_POLY;
      end
      return c;
    endfunction

    function void clear_packet();
      in_packet = 1'b0;
      pos = '0;
      crc_acc = '0;
      sum_acc = '0;
      check_hi = '0;
    endfunction

    function void owe(xpr_pkg::res_t r);
      outputs_due = {outputs_due, r};
    endfunction

    function xpr_pkg::res_t reply(logic [7:0] v, logic pend, logic acc, logic done);
      return xpr_pkg::res_t'{kind: xpr_pkg::KIND_REPLY, byte_value: v, packet_end: pend,
                             accepted: acc, transfer_done: done};
    endfunction

    function void set_crc(bit v);
      crc_mode = v;
    endfunction

    function int pending();
      return outputs_due.size();
    endfunction

    function void predict_line_item(xpr_pkg::mode_e m, logic [7:0] b);
      bit ok;
      if (m == xpr_pkg::MODE_START) begin
        clear_packet();
        owe(reply(crc_mode ? xpr_pkg::BYTE_C : xpr_pkg::BYTE_NAK, 1'b0, 1'b0, 1'b0));
      end else if (!in_packet) begin
        if (b == xpr_pkg::BYTE_EOT) begin
          owe(reply(xpr_pkg::BYTE_ACK, 1'b0, 1'b0, 1'b1));
        end else begin
          clear_packet();
          in_packet = 1'b1;
        end
      end else if (pos < xpr_pkg::POS_DATA_FIRST) begin
        pos = pos + 1'b1;
      end else if (pos < xpr_pkg::POS_CHECK_HI) begin
        crc_acc = crc16_step(crc_acc, b);
        sum_acc = sum_acc + b;
        pos = pos + 1'b1;
        owe(xpr_pkg::res_t'{kind: xpr_pkg::KIND_DATA, byte_value: b, packet_end: 1'b0,
                            accepted: 1'b0, transfer_done: 1'b0});
      end else if (crc_mode && pos == xpr_pkg::POS_CHECK_HI) begin
        check_hi = b;
        pos = pos + 1'b1;
      end else begin
        // The check is judged under the mode in force when the closing byte arrives.
        ok = crc_mode ? ({check_hi, b} == crc_acc) : (b == sum_acc);
        clear_packet();
        owe(reply(ok ? xpr_pkg::BYTE_ACK : xpr_pkg::BYTE_NAK, 1'b1, ok, 1'b0));
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("ERROR: %s", msg);
    endtask

    function string field_msg(string name, logic [7:0] g, logic [7:0] w);
      return $sformatf("result %0d: %s is %0h, expected %0h", results_seen, name, g, w);
    endfunction

    task check_result(xpr_pkg::res_t got);
      xpr_pkg::res_t want;
      if (outputs_due.size() == 0) begin
        report($sformatf("result %0h arrived with nothing expected", got));
        return;
      end
      want = outputs_due.pop_front();
      results_seen++;
      if (got.kind !== want.kind)
        report(field_msg("kind", 8'(got.kind), 8'(want.kind)));
      if (got.byte_value !== want.byte_value)
        report(field_msg("byte_value", got.byte_value, want.byte_value));
      if (got.packet_end !== want.packet_end)
        report(field_msg("packet_end", 8'(got.packet_end), 8'(want.packet_end)));
      if (got.accepted !== want.accepted)
        report(field_msg("accepted", 8'(got.accepted), 8'(want.accepted)));
      if (got.transfer_done !== want.transfer_done)
        report(field_msg("transfer_done", 8'(got.transfer_done), 8'(want.transfer_done)));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  xpr_in_if  in_if();
  xpr_out_if out_if();

  xmodem_packet_receiver_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  rx_scoreboard sb;
  bit crc_on = 1'b1;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int items_sent = 0;

  always #5 clk = ~clk;

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int seen_requests;
    int hold_left;
    seen_requests = 0;
    hold_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen_requests) begin
        seen_requests = hold_requests;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      sb.check_result(xpr_pkg::res_t'{kind: out_if.kind, byte_value: out_if.byte_value,
                                      packet_end: out_if.packet_end,
                                      accepted: out_if.accepted,
                                      transfer_done: out_if.transfer_done});
    end
  end

  task automatic send_item(input xpr_pkg::mode_e m, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= m;
    in_if.rx_byte <= b;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.predict_line_item(m, b);
    items_sent++;
  endtask

  // Header bytes, such as block numbers, may still sit in the pipeline without a result.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input bit v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    crc_on = v;
    sb.set_crc(v);
  endtask

  // Sends a packet framed for the current mode; keep > 0 cuts it after that many bytes.
  task automatic send_packet(input bit good, input int keep);
    logic [7:0]  pkt[$];
    logic [15:0] crc;
    logic [7:0]  sum;
    logic [7:0]  hdr;
    logic [7:0]  blk;
    logic [7:0]  fill;
    logic [7:0]  mask;
    int          style;
    crc = '0;
    sum = '0;
    blk = 8'($urandom);
    mask = 8'($urandom_range(1, 255));
    style = int'($urandom_range(7));
    hdr = ($urandom_range(9) == 0) ? 8'($urandom) : 8'h01;
    if (hdr == xpr_pkg::BYTE_EOT) hdr = 8'h02;
    pkt = {pkt, hdr};
    pkt = {pkt, blk};
    pkt = {pkt, ~blk};
    for (int i = 0; i < xpr_pkg::DATA_LEN; i++) begin
      case (style)
        0: fill = 8'h00;
        1: fill = 8'hFF;
        2: fill = (i % 2 == 1) ? 8'h55 : 8'hAA;
        default: fill = 8'($urandom);
      endcase
      crc = rx_scoreboard::crc16_step(crc, fill);
      sum = sum + fill;
      pkt = {pkt, fill};
    end
    if (crc_on) begin
      if (!good) begin
        if ($urandom_range(1) == 1) crc[15:8] = crc[15:8] ^ mask;
        else crc[7:0] = crc[7:0] ^ mask;
      end
      pkt = {pkt, crc[15:8]};
      pkt = {pkt, crc[7:0]};
    end else begin
      pkt = {pkt, (good ? sum : sum ^ mask)};
    end
    if (keep <= 0 || keep > pkt.size()) keep = pkt.size();
    for (int i = 0; i < keep; i++) send_item(xpr_pkg::MODE_BYTE, pkt[i]);
  endtask

  initial begin
    bit crc_sel[4];
    int send_sel[4];
    int recv_sel[4];
    int target;
    int pick;
    crc_sel = '{1'b1, 1'b0, 1'b0, 1'b1};
    send_sel = '{33, 54, 0, 0};
    recv_sel = '{54, 33, 0, 0};
    sb = new();
    in_if.valid = 1'b0;
    in_if.mode = 1'b0;
    in_if.rx_byte = 8'h00;
    send_idle_pct = send_sel[0];
    recv_idle_pct = recv_sel[0];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, still in the CRC mode that reset selects.
    send_item(xpr_pkg::MODE_START, 8'h00);
    send_item(xpr_pkg::MODE_BYTE, xpr_pkg::BYTE_EOT);
    send_item(xpr_pkg::MODE_BYTE, 8'h01);
    send_item(xpr_pkg::MODE_BYTE, 8'h00);
    send_item(xpr_pkg::MODE_BYTE, 8'hFF);
    send_item(xpr_pkg::MODE_BYTE, 8'h00);
    send_item(xpr_pkg::MODE_BYTE, 8'hFF);
    send_item(xpr_pkg::MODE_START, 8'hFF);
    send_item(xpr_pkg::MODE_BYTE, 8'hFF);
    send_item(xpr_pkg::MODE_BYTE, 8'h80);
    send_item(xpr_pkg::MODE_BYTE, 8'h7F);
    send_item(xpr_pkg::MODE_BYTE, 8'hA5);
    // Switch to checksum mode while a packet is open.
    wait_idle();
    write_cfg(1'b0);
    send_item(xpr_pkg::MODE_BYTE, 8'h5A);
    send_item(xpr_pkg::MODE_START, 8'h00);
    send_item(xpr_pkg::MODE_BYTE, xpr_pkg::BYTE_EOT);
    send_item(xpr_pkg::MODE_START, 8'hFF);

    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_cfg(crc_sel[p]);
      send_idle_pct = send_sel[p];
      recv_idle_pct = recv_sel[p];
      // A stray byte may close a packet left open under the other mode; start then resyncs.
      send_item(xpr_pkg::MODE_BYTE, 8'($urandom));
      send_item(xpr_pkg::MODE_START, 8'($urandom));
      if (p == 0) hold_requests++;
      target = items_sent + 260;
      while (items_sent < target) begin
        pick = int'($urandom_range(99));
        if (pick < 72) begin
          send_packet($urandom_range(99) < 70, 0);
        end else if (pick < 80) begin
          send_item(xpr_pkg::MODE_BYTE, xpr_pkg::BYTE_EOT);
        end else if (pick < 87) begin
          send_item(xpr_pkg::MODE_START, 8'($urandom));
        end else begin
          send_packet(1'($urandom_range(1)), int'($urandom_range(1, 130)));
          repeat ($urandom_range(1, 12))
            send_item(xpr_pkg::mode_e'($urandom_range(1)), 8'($urandom));
          send_item(xpr_pkg::MODE_START, 8'($urandom));
        end
      end
      // Leave the packet one byte short of its end so the next mode decides it.
      send_packet(1'($urandom_range(1)),
                  int'(xpr_pkg::NUM_HDR + xpr_pkg::DATA_LEN) + (crc_on ? 2 : 1));
    end

    wait_idle();
    repeat (6) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
